[rtl/wsws_pkg.sv]
package wsws_pkg;

    // Slot and stack geometry
    localparam int MAX_SLOTS     = 8;
    localparam int SLOT_BITS     = $clog2(MAX_SLOTS);
    localparam int CNT_BITS      = $clog2(MAX_SLOTS + 1);
    localparam int NUM_STACKS    = 2 * MAX_SLOTS;
    localparam int STK_BITS      = SLOT_BITS + 1;
    localparam int STACK_DEPTH   = 16;
    localparam int DEPTH_BITS    = $clog2(STACK_DEPTH);
    localparam int FILL_BITS     = $clog2(STACK_DEPTH + 1);
    localparam int WORKER_BITS   = 8;
    localparam int MEM_DEPTH     = NUM_STACKS * STACK_DEPTH;
    localparam int MEM_ADDR_BITS = STK_BITS + DEPTH_BITS;

    // Port field widths
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 3;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_SLOTS);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_READY_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE_PUSH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP        = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FINISH     = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READY_LEFT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT    = 2'd3;

endpackage

[rtl/work_stealing_worker_scheduler_core.sv]
// Work-stealing worker scheduler: every processor slot owns two LIFO stacks of worker
// ids, one in the ready role and one in the done role. Items arrive on the in_valid /
// in_ready channel (action, slot_index, worker_id) and each produces exactly one
// result item on the out_valid / out_ready channel (popped_worker, found, status).
// A push, a finish, a bad-slot item or a pop that finds every ready stack empty is
// answered from the output register in the cycle after acceptance, so these items can
// follow one another every cycle while results are taken. A pop that finds an id
// passes through S_READ: the rotating priority search and fill update happen in the
// accept cycle; S_READ then moves the id from the memory's read register to the output.
// The number of slots searched is set by cfg_wr_en / cfg_wr_data (active count).
// Reset clears every fill count and role bit and sets the active count to eight;
// the stack memory is not cleared, as only entries below a stack's fill are read.
// When the receiver stalls, a finished result waits in the output register and no
// further item is accepted until that result has been taken.
module work_stealing_worker_scheduler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wsws_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wsws_pkg::ACTION_W-1:0]  action,
    input  logic [wsws_pkg::SLOT_W-1:0]    slot_index,
    input  logic [wsws_pkg::ID_W-1:0]      worker_id,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wsws_pkg::ID_W-1:0]      popped_worker,
    output logic                           found,
    output logic [wsws_pkg::STATUS_W-1:0]  status
);
    import wsws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         active_reg;
    logic [FILL_BITS-1:0]     fill_reg [NUM_STACKS];
    logic [MAX_SLOTS-1:0]     role_reg, role_next;

    logic                     out_valid_reg, out_valid_next;
    logic [ID_W-1:0]          popped_reg, popped_next;
    logic                     found_reg, found_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    // Stack memory: one write port, one registered read port
    logic [WORKER_BITS-1:0]   stack_mem [MEM_DEPTH];
    logic [WORKER_BITS-1:0]   mem_rdata_reg;
    logic                     mem_we, mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_waddr, mem_raddr;

    logic [CNT_BITS-1:0]      n_slots;
    logic [MAX_SLOTS-1:0]     active_mask, ready_ne, cand, upper, pick_vec;
    logic [SLOT_BITS-1:0]     sel_slot, req_slot;
    logic                     any_cand, bad_slot, accept, out_free;
    logic [STK_BITS-1:0]      push_stk, pop_stk, upd_stk;
    logic                     push_full, fill_inc, fill_dec;
    logic [FILL_BITS-1:0]     pop_fill_m1;

    // Active count, clamped into 1..MAX_SLOTS
    always_comb
    begin
        if (active_reg == '0)
            n_slots = CNT_BITS'(1);
        else if (CNT_BITS'(active_reg) > CNT_BITS'(MAX_SLOTS))
            n_slots = CNT_BITS'(MAX_SLOTS);
        else
            n_slots = CNT_BITS'(active_reg);
    end

    assign req_slot = slot_index[SLOT_BITS-1:0];
    assign bad_slot = (CNT_BITS'(slot_index) >= n_slots);

    // Per-slot nonempty flags of the ready stacks, and the rotating priority search:
    // slots from the requested one upwards first, then from slot zero.
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            active_mask[i] = (CNT_BITS'(i) < n_slots);
            ready_ne[i]    = (fill_reg[{SLOT_BITS'(i), role_reg[i]}] != '0);
            cand[i]        = active_mask[i] && ready_ne[i];
            upper[i]       = cand[i] && (SLOT_BITS'(i) >= req_slot);
        end
    end

    assign any_cand = |cand;
    assign pick_vec = (|upper) ? upper : cand;

    always_comb
    begin
        sel_slot = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (pick_vec[i])
                sel_slot = SLOT_BITS'(i);
        end
    end

    assign push_stk    = {req_slot, role_reg[req_slot] ^ (action == ACT_DONE_PUSH)};
    assign pop_stk     = {sel_slot, role_reg[sel_slot]};
    assign push_full   = (fill_reg[push_stk] == FILL_BITS'(STACK_DEPTH));
    assign pop_fill_m1 = fill_reg[pop_stk] - FILL_BITS'(1);

    // The output register may be loaded when it is empty or being emptied
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Main decision logic: fill updates, memory access and result formation
    always_comb
    begin
        state_next     = state_reg;
        role_next      = role_reg;
        out_valid_next = out_valid_reg && !out_ready;
        popped_next    = popped_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = {push_stk, fill_reg[push_stk][DEPTH_BITS-1:0]};
        mem_raddr      = {pop_stk, pop_fill_m1[DEPTH_BITS-1:0]};
        fill_inc       = 1'b0;
        fill_dec       = 1'b0;
        upd_stk        = push_stk;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    if (action == ACT_FINISH)
                    begin
                        out_valid_next = 1'b1;
                        if (|(ready_ne & active_mask))
                            status_next = ST_READY_LEFT;
                        else
                            role_next = role_reg ^ active_mask;
                    end
                    else if (bad_slot)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_BAD_SLOT;
                    end
                    else if (action == ACT_POP)
                    begin
                        if (any_cand)
                        begin
                            // Result follows once the memory read returns
                            mem_re     = 1'b1;
                            fill_dec   = 1'b1;
                            upd_stk    = pop_stk;
                            state_next = S_READ;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (push_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we   = 1'b1;
                            fill_inc = 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    popped_next    = ID_W'(mem_rdata_reg);
                    found_next     = 1'b1;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= ACTIVE_RESET;
            role_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            role_reg      <= role_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                active_reg <= cfg_wr_data;
            if (fill_inc)
                fill_reg[upd_stk] <= fill_reg[upd_stk] + FILL_BITS'(1);
            else if (fill_dec)
                fill_reg[upd_stk] <= pop_fill_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // A pop holds the block in S_READ, so no write can meet its read in flight
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= worker_id[WORKER_BITS-1:0];
        if (mem_re)
            mem_rdata_reg <= stack_mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign popped_worker = popped_reg;
    assign found         = found_reg;
    assign status        = status_reg;

`ifndef SYNTHESIS
    a_pop_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_POP && !bad_slot && any_cand) |=> (state_reg == S_READ))
        else $error("successful pop did not start a memory read");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK))
        else $error("found result carries an error status");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (popped_worker == '0))
        else $error("result without a find carries a worker id");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && out_free) |=> (out_valid && found && state_reg == S_IDLE))
        else $error("pop read did not deliver its result");
`endif

endmodule

[tb/sv/tb.sv]
module tb;
    import wsws_pkg::*;

    // One item as offered on the input channel.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
    } sched_item_t;

    // One answer as it should appear on the output channel.
    typedef struct packed {
        logic [ID_W-1:0]     popped;
        logic                found;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    // Every input of the block starts at a known value, reset included.
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data   = '0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action        = '0;
    logic [SLOT_W-1:0]   slot_index    = '0;
    logic [ID_W-1:0]     worker_id     = '0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [ID_W-1:0]     popped_worker;
    logic                found;
    logic [STATUS_W-1:0] status;

    work_stealing_worker_scheduler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .slot_index    (slot_index),
        .worker_id     (worker_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .popped_worker (popped_worker),
        .found         (found),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Items waiting to be offered, and answers waiting to come out.
    sched_item_t   items_pending [$];
    sched_result_t answers_due   [$];

    // Idling rates in percent, changed by the sequencer between phases.
    int unsigned send_idle    = 16;
    int unsigned recv_idle    = 47;
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned phase_items  = 0;

    // The scheduler as the testbench believes it to be. The reset state is the
    // zero default of these arrays, and reset is applied only once.
    logic [ID_W-1:0]  stack_words  [NUM_STACKS][STACK_DEPTH];
    int unsigned      stack_count  [NUM_STACKS];
    bit               slot_flipped [MAX_SLOTS];
    logic [CFG_W-1:0] active_setting = ACTIVE_RESET;

    // The register is clamped: zero behaves as one slot and anything above the
    // slot count behaves as all slots.
    function automatic int unsigned slots_live();
        if (active_setting == 0)
            return 1;
        if (active_setting > MAX_SLOTS)
            return MAX_SLOTS;
        return 32'(active_setting);
    endfunction

    // Index of the stack holding a slot's ready role, or its done role.
    function automatic int unsigned stack_of(int unsigned s, bit done_role);
        return s * 2 + (slot_flipped[s] ^ done_role);
    endfunction

    function automatic logic [STATUS_W-1:0] push_worker(int unsigned stk,
                                                        logic [ID_W-1:0] id);
        if (stack_count[stk] >= STACK_DEPTH)
            return ST_FULL;
        stack_words[stk][stack_count[stk]] = id;
        stack_count[stk]++;
        return ST_OK;
    endfunction

    // Applies one accepted item to the believed state and returns its answer.
    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t r;
        int unsigned   n;
        int unsigned   stk;
        int unsigned   i;
        r = '0;
        n = slots_live();
        if (it.action == ACT_FINISH)
        begin
            // Any ready work left in an active slot blocks the swap for all.
            for (i = 0; i < n; i++)
                if (stack_count[stack_of(i, 1'b0)] != 0)
                    r.status = ST_READY_LEFT;
            if (r.status == ST_OK)
                for (i = 0; i < n; i++)
                    slot_flipped[i] = ~slot_flipped[i];
        end
        else if (it.slot >= n)
        begin
            r.status = ST_BAD_SLOT;
        end
        else if (it.action == ACT_READY_PUSH)
        begin
            r.status = push_worker(stack_of(32'(it.slot), 1'b0), it.id);
        end
        else if (it.action == ACT_DONE_PUSH)
        begin
            r.status = push_worker(stack_of(32'(it.slot), 1'b1), it.id);
        end
        else
        begin
            // Own slot first, then steal round the active slots in order.
            for (i = 0; i < n && !r.found; i++)
            begin
                stk = stack_of((it.slot + i) % n, 1'b0);
                if (stack_count[stk] != 0)
                begin
                    stack_count[stk]--;
                    r.popped = stack_words[stk][stack_count[stk]];
                    r.found  = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s is %0d, should be %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [SLOT_W-1:0] live_slot(int unsigned n);
        return SLOT_W'($urandom_range(n - 1));
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] a, input logic [SLOT_W-1:0] s,
                              input logic [ID_W-1:0] w);
        items_pending.push_back('{a, s, w});
        phase_items++;
    endtask

    // Returns once every item has been taken and answered, and then lets the
    // block settle so that nothing is still moving inside it. The checks are made
    // at the falling edge, when the driver and monitor have settled.
    task automatic wait_drained();
        @(negedge clk);
        while (items_pending.size() != 0 || in_valid || answers_due.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Driver. An item accepted at this edge is handed to the predictor, and the
    // next one is offered unless the sender chooses to idle. An item already on
    // offer is held, payload and all, until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        sched_item_t offer;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= '0;
            slot_index <= '0;
            worker_id  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                offer = '{action, slot_index, worker_id};
                answers_due.push_back(schedule_step(offer));
            end
            if (!in_valid || in_ready)
            begin
                if (items_pending.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    offer = items_pending.pop_front();
                    in_valid   <= 1'b1;
                    action     <= offer.action;
                    slot_index <= offer.slot;
                    worker_id  <= offer.id;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Besides random idling it now and then refuses results for a
    // long stretch while the sender still has items queued, so that the output
    // register fills and the input channel backs up.
    int unsigned hold_left     = 0;
    int unsigned next_stall_at = 10;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (results_seen >= next_stall_at && items_pending.size() > 4)
        begin
            out_ready     <= 1'b0;
            hold_left     <= 200;
            next_stall_at <= next_stall_at + 300;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor. Each result taken is checked against the oldest answer due.
    always @(posedge clk)
    begin : check_results
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                report_mismatch("result with no item outstanding, status", 32'(status), 0);
            end
            else
            begin
                want = answers_due.pop_front();
                if (popped_worker !== want.popped)
                    report_mismatch("popped_worker", 32'(popped_worker), 32'(want.popped));
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
            results_seen <= results_seen + 1;
        end
    end

    // Sequencer: a directed opening, then phases of random work, each phase
    // under its own active count and the three idling regimes in turn.
    initial
    begin
        int unsigned phase;
        int unsigned pick;
        int unsigned n;
        int unsigned owed;
        int unsigned r_cnt;
        int unsigned d_cnt;
        int unsigned k;
        int unsigned cnt;
        int unsigned s;
        bit          which;
        int unsigned phase_cfg [9];

        phase_cfg = '{8, 3, 0, 15, 1, 5, 9, 8, 6};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme ids on the first and last slot plus one done item, then a pop
        // of the lowest id, a pop that must steal, and a pop with nothing left.
        queue_item(ACT_READY_PUSH, SLOT_W'(0), 8'h00);
        queue_item(ACT_READY_PUSH, SLOT_W'(7), 8'hFF);
        queue_item(ACT_DONE_PUSH, SLOT_W'(3), 8'hAA);
        queue_item(ACT_POP, SLOT_W'(0), 8'h5A);
        queue_item(ACT_POP, SLOT_W'(0), 8'hFF);
        queue_item(ACT_POP, SLOT_W'(4), 8'h00);
        // A finish that swaps, one refused because the swapped-in ready stack
        // is not empty, a steal that wraps round to it, and a clean finish.
        queue_item(ACT_FINISH, SLOT_W'(6), 8'h11);
        queue_item(ACT_FINISH, SLOT_W'(0), 8'hEE);
        queue_item(ACT_POP, SLOT_W'(5), 8'h33);
        queue_item(ACT_FINISH, SLOT_W'(7), 8'hFF);
        // One slot's ready stack filled to the brim and one push beyond it.
        for (k = 0; k <= STACK_DEPTH; k++)
            queue_item(ACT_READY_PUSH, SLOT_W'(2), ID_W'(k * 15));
        wait_drained();

        for (phase = 0; phase < 9; phase++)
        begin
            if (phase == 3)
            begin
                send_idle = 47;
                recv_idle = 16;
            end
            else if (phase == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end

            // The block is idle here, so the register may change.
            @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= CFG_W'(phase_cfg[phase]);
            active_setting = CFG_W'(phase_cfg[phase]);
            @(posedge clk);
            cfg_wr_en <= 1'b0;

            phase_items = 0;
            while (phase_items < 40)
            begin
                n    = slots_live();
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    // A full round: pushes of both kinds, enough pops to empty every ready
                    // stack (up to two spare), at times an item on an unused slot, then a finish.
                    owed = 0;
                    for (k = 0; k < n; k++)
                        owed += stack_count[stack_of(k, 1'b0)];
                    r_cnt = $urandom_range(6);
                    d_cnt = $urandom_range(6);
                    while (r_cnt + d_cnt != 0)
                    begin
                        if (d_cnt == 0 || (r_cnt != 0 && $urandom_range(1) == 1))
                        begin
                            queue_item(ACT_READY_PUSH, live_slot(n),
                                       ID_W'($urandom_range(255)));
                            r_cnt--;
                            owed++;
                        end
                        else
                        begin
                            queue_item(ACT_DONE_PUSH, live_slot(n),
                                       ID_W'($urandom_range(255)));
                            d_cnt--;
                        end
                    end
                    owed += $urandom_range(2);
                    for (k = 0; k < owed; k++)
                        queue_item(ACT_POP, live_slot(n), ID_W'($urandom_range(255)));
                    if (n < MAX_SLOTS && $urandom_range(3) == 0)
                        queue_item(ACTION_W'($urandom_range(ACT_POP, ACT_READY_PUSH)),
                                   SLOT_W'($urandom_range(MAX_SLOTS - 1, n)),
                                   ID_W'($urandom_range(255)));
                    queue_item(ACT_FINISH, SLOT_W'($urandom_range(7)),
                               ID_W'($urandom_range(255)));
                end
                else if (pick < 75)
                begin
                    // Fill one stack to the top and push once or twice more.
                    s     = live_slot(n);
                    which = 1'($urandom_range(1));
                    cnt   = STACK_DEPTH - stack_count[stack_of(s, which)]
                            + $urandom_range(1, 2);
                    for (k = 0; k < cnt; k++)
                        queue_item(which ? ACT_DONE_PUSH : ACT_READY_PUSH, SLOT_W'(s),
                                   ID_W'($urandom_range(255)));
                end
                else
                begin
                    // Noise: any action on any slot, bad slots included.
                    cnt = $urandom_range(4, 10);
                    for (k = 0; k < cnt; k++)
                        queue_item(ACTION_W'($urandom_range(ACT_FINISH, ACT_READY_PUSH)),
                                   SLOT_W'($urandom_range(7)),
                                   ID_W'($urandom_range(255)));
                end
                wait_drained();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("[work_stealing_worker_scheduler_core] OK");
        else
            $display("[work_stealing_worker_scheduler_core] ERROR");
        $finish;
    end

    // Far beyond the slowest correct run; reaching it means the block hung.
    initial
    begin
        #2000000;
        $display("[work_stealing_worker_scheduler_core] ERROR");
        $finish;
    end

endmodule
